### src/frpr_pkg.sv
package frpr_pkg;

   // default payload capacity and frame layout
   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int HDR_BYTES       = 7;
   localparam int POS_VERSION     = 2;
   localparam int POS_LENGTH      = 8;
   localparam int POS_DATA        = 9;
   localparam int OVERHEAD        = 11;
   localparam int IDX_W           = 6;
   localparam int CNT_W           = 7;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LEN_ERR  = 3'd1;
   localparam logic [2:0] ST_TOO_LONG = 3'd2;
   localparam logic [2:0] ST_BAD_VER  = 3'd3;
   localparam logic [2:0] ST_CRC_ERR  = 3'd4;

   // control register indexes
   localparam logic [1:0] CSR_START_FIRST  = 2'd0;
   localparam logic [1:0] CSR_START_SECOND = 2'd1;
   localparam logic [1:0] CSR_VERSION      = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [7:0] start_first;
      logic [7:0] start_second;
      logic [7:0] version;
   } cfg_type;

   // one finished frame or one error, handed from parser to emitter
   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       flag_bits;
      logic [7:0]       dest_addr;
      logic [7:0]       source_addr;
      logic [7:0]       seq_number;
      logic [7:0]       command_code;
      logic [CNT_W-1:0] len;
      logic             bank;
   } job_type;

   // payload buffer write
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } pwr_type;

   // buffer bank handed back by the emitter
   typedef struct packed {
      logic en;
      logic bank;
   } rel_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       flag_bits;
      logic [7:0]       dest_addr;
      logic [7:0]       source_addr;
      logic [7:0]       seq_number;
      logic [7:0]       command_code;
      logic [CNT_W-1:0] payload_count;
      logic [7:0]       payload_byte;
      logic [IDX_W-1:0] payload_pos;
      logic             last;
   } out_type;

   // crc-16/modbus update by one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### src/frpr_front.sv
module frpr_front import frpr_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       stall,
   input  logic       q_full,
   output logic       job_push,
   output job_type    job,
   output pwr_type    pwr,
   input  rel_type    rel
);

   localparam int FRAME_MAX = OVERHEAD + MAX_PAYLOAD;

   logic [CNT_W-1:0] bc_ff, bc_in;
   logic [CNT_W-1:0] flen_ff, flen_in;
   logic [7:0]       hdr_ff [HDR_BYTES];
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff;
   logic             wr_bank_ff, wr_bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             hdr_we;
   logic [2:0]       hdr_idx;
   logic             lo_we;
   logic [CNT_W-1:0] pidx;

   // hold off input while the job queue is full or the payload bank is still read out
   assign stall = q_full || ((bc_ff >= CNT_W'(POS_DATA)) && busy_ff[wr_bank_ff]);

   assign pidx = bc_ff - CNT_W'(POS_DATA);

   // byte parser
   always_comb begin
      bc_in      = bc_ff;
      flen_in    = flen_ff;
      crc_in     = crc_ff;
      wr_bank_in = wr_bank_ff;
      hdr_we     = 1'b0;
      hdr_idx    = 3'(bc_ff - CNT_W'(POS_VERSION));
      lo_we      = 1'b0;
      job_push   = 1'b0;
      job        = '0;
      job.bank   = wr_bank_ff;
      pwr.en     = 1'b0;
      pwr.bank   = wr_bank_ff;
      pwr.idx    = pidx[IDX_W-1:0];
      pwr.data   = byte_data;
      if (byte_valid && !stall) begin
         if (bc_ff == '0) begin
            if (byte_data == cfg.start_first) begin
               bc_in = CNT_W'(1);
            end
         end else if (bc_ff == CNT_W'(1)) begin
            if (byte_data == cfg.start_first) begin
               bc_in = CNT_W'(1);
            end else if (byte_data == cfg.start_second) begin
               bc_in = CNT_W'(2);
            end else begin
               bc_in = '0;
            end
         end else if (bc_ff >= CNT_W'(FRAME_MAX)) begin
            job_push   = 1'b1;
            job.status = ST_LEN_ERR;
         end else begin
            bc_in = bc_ff + CNT_W'(1);
            if (bc_ff <= CNT_W'(POS_LENGTH)) begin
               hdr_we = 1'b1;
               crc_in = crc_feed(crc_ff, byte_data);
               if (bc_ff == CNT_W'(POS_LENGTH)) begin
                  if (byte_data > 8'(MAX_PAYLOAD)) begin
                     job_push   = 1'b1;
                     job.status = ST_TOO_LONG;
                  end else begin
                     flen_in = CNT_W'(OVERHEAD) + byte_data[CNT_W-1:0];
                  end
               end
            end else if (flen_ff < CNT_W'(OVERHEAD)) begin
               job_push   = 1'b1;
               job.status = ST_LEN_ERR;
            end else if (bc_ff < flen_ff - CNT_W'(2)) begin
               pwr.en = pidx < CNT_W'(MAX_PAYLOAD);
               crc_in = crc_feed(crc_ff, byte_data);
            end else if (bc_ff == flen_ff - CNT_W'(2)) begin
               lo_we = 1'b1;
            end else if (bc_ff != flen_ff - CNT_W'(1)) begin
               job_push   = 1'b1;
               job.status = ST_LEN_ERR;
            end else if (hdr_ff[0] != cfg.version) begin
               job_push   = 1'b1;
               job.status = ST_BAD_VER;
            end else if ({byte_data, crc_lo_ff} != crc_ff) begin
               job_push   = 1'b1;
               job.status = ST_CRC_ERR;
            end else begin
               job_push         = 1'b1;
               job.status       = ST_OK;
               job.flag_bits    = hdr_ff[1];
               job.dest_addr    = hdr_ff[2];
               job.source_addr  = hdr_ff[3];
               job.seq_number   = hdr_ff[4];
               job.command_code = hdr_ff[5];
               job.len          = hdr_ff[6][CNT_W-1:0];
               if (hdr_ff[6] != 8'h00) begin
                  wr_bank_in = !wr_bank_ff;
               end
            end
         end
         // any frame end returns to hunting
         if (job_push) begin
            bc_in   = '0;
            flen_in = '0;
            crc_in  = CRC_INIT;
         end
      end
   end

   // bank ownership: claimed at a good frame with payload, freed by the emitter
   always_comb begin
      busy_in = busy_ff;
      if (rel.en) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (job_push && job.status == ST_OK && job.len != '0) begin
         busy_in[wr_bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff      <= '0;
         flen_ff    <= '0;
         crc_ff     <= CRC_INIT;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         bc_ff      <= bc_in;
         flen_ff    <= flen_in;
         crc_ff     <= crc_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

   // header bytes and low crc byte
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[hdr_idx] <= byte_data;
      end
      if (lo_we) begin
         crc_lo_ff <= byte_data;
      end
   end

   // payload never lands in a bank that is still being read out
   a_pwr_free_bank: assert property (@(posedge clock) disable iff (reset)
      pwr.en |-> !busy_ff[pwr.bank])
      else $error("payload write into busy bank");

   // a released bank was owned
   a_rel_owned: assert property (@(posedge clock) disable iff (reset)
      rel.en |-> busy_ff[rel.bank])
      else $error("release of a free bank");

endmodule

### src/frpr_jobq.sv
module frpr_jobq import frpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type head
);

   localparam int DEPTH = 2;

   job_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'(DEPTH);
   assign valid = cnt_ff != '0;
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/frpr_back.sv
module frpr_back import frpr_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  pwr_type pwr,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output rel_type rel,
   output logic    out_empty,
   input  logic    out_pop,
   output out_type out_item
);

   localparam int AW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int MEM_D    = 2 * (2 ** AW);
   localparam int OQ_DEPTH = 4;

   logic [7:0]       pay_mem_ff [MEM_D];
   logic [7:0]       rd_ff;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             fly_ff;
   out_type          meta_ff, meta_in;
   logic             zero_ff, zero_in;

   out_type          oq_ff [OQ_DEPTH];
   logic [1:0]       oq_wr_ff, oq_rd_ff;
   logic [2:0]       oq_cnt_ff, oq_cnt_in;
   logic             oq_we, oq_re;
   out_type          oq_wdata;

   logic             issue;
   logic             is_err;
   logic [CNT_W-1:0] n_items;
   logic             last;

   // payload buffer, two banks
   always_ff @(posedge clock) begin
      if (pwr.en) begin
         pay_mem_ff[{pwr.bank, pwr.idx[AW-1:0]}] <= pwr.data;
      end
      if (issue) begin
         rd_ff <= pay_mem_ff[{job.bank, k_ff[AW-1:0]}];
      end
   end

   // item sequencer: one item per cycle while the result queue has room
   assign is_err  = job.status != ST_OK;
   assign n_items = (is_err || job.len == '0) ? CNT_W'(1) : job.len;
   assign last    = k_ff == n_items - CNT_W'(1);
   assign issue   = job_valid && ((oq_cnt_ff + {2'b00, fly_ff}) < 3'(OQ_DEPTH));
   assign job_pop = issue && last;
   assign rel.en  = job_pop && !is_err && job.len != '0;
   assign rel.bank = job.bank;
   assign k_in    = job_pop ? '0 : (issue ? k_ff + CNT_W'(1) : k_ff);

   always_comb begin
      meta_in               = '0;
      meta_in.status        = job.status;
      meta_in.flag_bits     = job.flag_bits;
      meta_in.dest_addr     = job.dest_addr;
      meta_in.source_addr   = job.source_addr;
      meta_in.seq_number    = job.seq_number;
      meta_in.command_code  = job.command_code;
      meta_in.payload_count = job.len;
      meta_in.payload_pos   = (is_err || job.len == '0) ? '0 : k_ff[IDX_W-1:0];
      meta_in.last          = last;
      zero_in               = is_err || job.len == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         fly_ff <= 1'b0;
      end else begin
         k_ff   <= k_in;
         fly_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         meta_ff <= meta_in;
         zero_ff <= zero_in;
      end
   end

   // result queue
   always_comb begin
      oq_wdata              = meta_ff;
      oq_wdata.payload_byte = zero_ff ? 8'h00 : rd_ff;
   end

   assign oq_we     = fly_ff;
   assign oq_re     = out_pop && !out_empty;
   assign out_empty = oq_cnt_ff == '0;
   assign out_item  = oq_ff[oq_rd_ff];

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (oq_we && !oq_re) begin
         oq_cnt_in = oq_cnt_ff + 3'd1;
      end else if (oq_re && !oq_we) begin
         oq_cnt_in = oq_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_we ? oq_wr_ff + 2'd1 : oq_wr_ff;
         oq_rd_ff  <= oq_re ? oq_rd_ff + 2'd1 : oq_rd_ff;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_we) begin
         oq_ff[oq_wr_ff] <= oq_wdata;
      end
   end

   // reads in flight never overrun the result queue
   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      (oq_cnt_ff + {2'b00, fly_ff}) <= 3'(OQ_DEPTH))
      else $error("result queue overrun");

   // an item read from the buffer shows up in the result queue
   a_oq_filled: assert property (@(posedge clock) disable iff (reset)
      issue |=> ##1 !out_empty)
      else $error("issued item missing from result queue");

endmodule

### src/framed_packet_receiver_crc16.sv
// Byte-serial frame receiver. One byte is taken per cycle on req_push/req_full;
// the parser hunts for the two start bytes, collects the seven header bytes,
// stores the payload in a two-bank buffer and checks version and CRC-16/MODBUS
// (init 0xFFFF, reflected poly 0xA001, CRC sent low byte first). Each frame
// end goes to a two-entry job queue; the emitter then gives one result per
// payload byte (one result for an empty payload or an error) at one result per
// cycle while the four-entry result queue has room, as fast as the RAM is read.
// A frame's first result passes the job queue, the RAM read and the result queue.
// req_full rises while the job queue is full, or from the first payload byte
// position of a frame onward while the buffer bank it writes is still being read
// out. With rsp_pop held high a byte is taken every cycle as long as the results
// keep up: a long payload drains at one result per cycle, so short frames that
// follow it can fill the job queue or reach the busy bank and hold req_full high
// until the emitter catches up.
module framed_packet_receiver_crc16 import frpr_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_in_byte,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_flag_bits,
   output logic [7:0]       rsp_dest_addr,
   output logic [7:0]       rsp_source_addr,
   output logic [7:0]       rsp_seq_number,
   output logic [7:0]       rsp_command_code,
   output logic [CNT_W-1:0] rsp_payload_count,
   output logic [7:0]       rsp_payload_byte,
   output logic [IDX_W-1:0] rsp_payload_pos,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, job_push, job_valid, job_pop;
   job_type push_job, head_job;
   pwr_type pwr;
   rel_type rel;
   out_type out_item;

   // control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_FIRST:  cfg_in.start_first  = csr_wr_data;
            CSR_START_SECOND: cfg_in.start_second = csr_wr_data;
            CSR_VERSION:      cfg_in.version      = csr_wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_first  <= 8'hAA;
         cfg_ff.start_second <= 8'h55;
         cfg_ff.version      <= 8'h01;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   frpr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_push),
      .byte_data  (req_in_byte),
      .stall      (req_full),
      .q_full     (q_full),
      .job_push   (job_push),
      .job        (push_job),
      .pwr        (pwr),
      .rel        (rel)
   );

   frpr_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .head     (head_job)
   );

   frpr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pwr       (pwr),
      .job_valid (job_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rel       (rel),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_item  (out_item)
   );

   // result ports
   assign rsp_status        = out_item.status;
   assign rsp_flag_bits     = out_item.flag_bits;
   assign rsp_dest_addr     = out_item.dest_addr;
   assign rsp_source_addr   = out_item.source_addr;
   assign rsp_seq_number    = out_item.seq_number;
   assign rsp_command_code  = out_item.command_code;
   assign rsp_payload_count = out_item.payload_count;
   assign rsp_payload_byte  = out_item.payload_byte;
   assign rsp_payload_pos   = out_item.payload_pos;
   assign rsp_last          = out_item.last;

endmodule
